FILE: hdl/vertex_normal_accumulator_assert.svh
// ----------------------------------------------------------------------------
// vertex normal accumulator assertion macros
// shared checks, written in modules that have clk_i and rst_ni in scope
// ----------------------------------------------------------------------------
`ifndef VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH
`define VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define VNA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vertex normal accumulator check failed");

// next-cycle implication
`define VNA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vertex normal accumulator check failed");

`endif

FILE: hdl/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// shared constants, action codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int unsigned VertexCountDef = 1024;
  localparam int unsigned SumWidthDef    = 24;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned POS_W = 32;
  localparam int unsigned NRM_W = 16;
  localparam int unsigned CNT_W = 5;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_TRI   = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] CORNER_A = 2'd0;
  localparam logic [1:0] CORNER_B = 2'd1;
  localparam logic [1:0] CORNER_C = 2'd2;

  typedef struct packed {
    logic       cap_in;
    logic       wr_vertex;
    logic       pos_rd;
    logic [1:0] rd_corner;
    logic       pos_cap;
    logic [1:0] cap_corner;
    logic       mul_en;
    logic [2:0] mul_step;
    logic       nrm_ld_cross;
    logic       nrm_ld_sum;
    logic       nrm_shift;
    logic       sq_clr;
    logic       sq_en;
    logic [1:0] sq_idx;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       sum_rd;
    logic       sum_wr;
    logic [1:0] sum_corner;
    logic       out_fire;
    logic       out_zero;
  } vna_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       a_ok;
    logic       tri_ok;
    logic       m_zero;
    logic       nrm_big;
    logic       nrm_small;
  } vna_sts_t;

endpackage

FILE: hdl/vertex_normal_accumulator.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// per-vertex position store and face-averaged Q1.14 normal accumulation
// ----------------------------------------------------------------------------
// usage:
//   an item is taken when start is high and busy is low. action selects
//   write vertex (position and cleared sum), add triangle, or read normal.
//   a read returns one result: done_o is high for exactly one cycle with
//   vertex_index_o, normal_x/y/z_o and zero_normal_o; the receiver cannot
//   hold it off. write and triangle items give no result.
// timing:
//   an out-of-range read still gives done_o. read and triangle items take
//   longer the more one-bit normalize shifts they need; the cost is set by
//   the one-bit-a-cycle square root and the dividers, plus three
//   read-modify-write passes over the sum store for a triangle.
//   one item at a time; busy stays high until the item is finished.
// reset:
//   clears the controller and the result strobe; the stores are not
//   cleared, entries read before being written return undefined values.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator #(
  parameter int unsigned VERTEX_COUNT = vna_pkg::VertexCountDef,
  parameter int unsigned SUM_WIDTH    = vna_pkg::SumWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       action_i,
  input  logic [vna_pkg::IDX_W-1:0]        index_a_i,
  input  logic [vna_pkg::IDX_W-1:0]        index_b_i,
  input  logic [vna_pkg::IDX_W-1:0]        index_c_i,
  input  logic signed [vna_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [vna_pkg::POS_W-1:0] pos_y_i,
  input  logic signed [vna_pkg::POS_W-1:0] pos_z_i,
  output logic                             done_o,
  output logic [vna_pkg::IDX_W-1:0]        vertex_index_o,
  output logic signed [vna_pkg::NRM_W-1:0] normal_x_o,
  output logic signed [vna_pkg::NRM_W-1:0] normal_y_o,
  output logic signed [vna_pkg::NRM_W-1:0] normal_z_o,
  output logic                             zero_normal_o
);
  import vna_pkg::*;

  vna_cmd_t cmd;
  vna_sts_t sts;

  vna_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  vna_datapath #(
    .VERTEX_COUNT (VERTEX_COUNT),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (action_i),
    .index_a_i      (index_a_i),
    .index_b_i      (index_b_i),
    .index_c_i      (index_c_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .done_o         (done_o),
    .vertex_index_o (vertex_index_o),
    .normal_x_o     (normal_x_o),
    .normal_y_o     (normal_y_o),
    .normal_z_o     (normal_z_o),
    .zero_normal_o  (zero_normal_o)
  );

endmodule

FILE: hdl/vna_datapath.sv
// ----------------------------------------------------------------------------
// vna_datapath
// vertex stores, edge/cross product, normalize (shift, squares, isqrt,
// divide) and saturating accumulate, all stepped by the controller
// ----------------------------------------------------------------------------
module vna_datapath #(
  parameter int unsigned VERTEX_COUNT = vna_pkg::VertexCountDef,
  parameter int unsigned SUM_WIDTH    = vna_pkg::SumWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  vna_pkg::vna_cmd_t                cmd_i,
  output vna_pkg::vna_sts_t                sts_o,
  input  logic [1:0]                       action_i,
  input  logic [vna_pkg::IDX_W-1:0]        index_a_i,
  input  logic [vna_pkg::IDX_W-1:0]        index_b_i,
  input  logic [vna_pkg::IDX_W-1:0]        index_c_i,
  input  logic signed [vna_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [vna_pkg::POS_W-1:0] pos_y_i,
  input  logic signed [vna_pkg::POS_W-1:0] pos_z_i,
  output logic                             done_o,
  output logic [vna_pkg::IDX_W-1:0]        vertex_index_o,
  output logic signed [vna_pkg::NRM_W-1:0] normal_x_o,
  output logic signed [vna_pkg::NRM_W-1:0] normal_y_o,
  output logic signed [vna_pkg::NRM_W-1:0] normal_z_o,
  output logic                             zero_normal_o
);
  import vna_pkg::*;

  localparam int AW     = $clog2(VERTEX_COUNT);
  localparam int PW     = 3 * POS_W;
  localparam int SW3    = 3 * SUM_WIDTH;
  localparam int EDGE_W = 31;
  localparam int PROD_W = 2 * EDGE_W;
  localparam int CRS_W  = 63;
  localparam int MAG_W  = 62;
  localparam int SQ_W   = 60;
  localparam int RT_W   = 63;
  localparam int LEN_W  = 31;
  localparam int NUM_W  = 45;
  localparam int REM_W  = 32;
  localparam logic [16:0] VcLim = 17'(VERTEX_COUNT);
  localparam logic signed [NRM_W-1:0] NrmOne = 16'sd16384;
  localparam logic signed [SUM_WIDTH:0] SumMax = (SUM_WIDTH+1)'((64'd1 << (SUM_WIDTH-1)) - 64'd1);
  localparam logic signed [SUM_WIDTH:0] SumMin = -SumMax - (SUM_WIDTH+1)'(1);

  // captured item
  logic [1:0]       act_q;
  logic [IDX_W-1:0] ia_q, ib_q, ic_q;
  logic [PW-1:0]    pin_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      act_q <= action_i;
      ia_q  <= index_a_i;
      ib_q  <= index_b_i;
      ic_q  <= index_c_i;
      pin_q <= {pos_x_i, pos_y_i, pos_z_i};
    end
  end

  logic a_ok, b_ok, c_ok;
  assign a_ok = 17'(ia_q) < VcLim;
  assign b_ok = 17'(ib_q) < VcLim;
  assign c_ok = 17'(ic_q) < VcLim;

  function automatic logic [IDX_W-1:0] corner_idx(input logic [1:0] c, input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b,
                                                  input logic [IDX_W-1:0] cc);
    logic [IDX_W-1:0] r;
    case (c)
      CORNER_A: r = a;
      CORNER_B: r = b;
      default:  r = cc;
    endcase
    return r;
  endfunction

  logic [AW-1:0] a_addr, pos_raddr, sum_addr;
  assign a_addr    = AW'(ia_q);
  assign pos_raddr = AW'(corner_idx(cmd_i.rd_corner, ia_q, ib_q, ic_q));
  assign sum_addr  = AW'(corner_idx(cmd_i.sum_corner, ia_q, ib_q, ic_q));

  // position store
  logic [PW-1:0] pos_mem [VERTEX_COUNT];
  logic [PW-1:0] pos_rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_vertex) begin
      pos_mem[a_addr] <= pin_q;
    end
    if (cmd_i.pos_rd) begin
      pos_rdata_q <= pos_mem[pos_raddr];
    end
  end

  // edges, each scaled so every magnitude is below 2^30
  function automatic logic [3*EDGE_W-1:0] shrink(input logic signed [POS_W:0] d0,
                                                 input logic signed [POS_W:0] d1,
                                                 input logic signed [POS_W:0] d2);
    logic [POS_W:0] m0, m1, m2, mo;
    logic [1:0]     sh;
    logic [POS_W:0] s0, s1, s2;
    logic [EDGE_W-1:0] r0, r1, r2;
    m0 = d0[POS_W] ? (~d0 + 1'b1) : d0;
    m1 = d1[POS_W] ? (~d1 + 1'b1) : d1;
    m2 = d2[POS_W] ? (~d2 + 1'b1) : d2;
    mo = m0 | m1 | m2;
    if (mo[32])      sh = 2'd3;
    else if (mo[31]) sh = 2'd2;
    else if (mo[30]) sh = 2'd1;
    else             sh = 2'd0;
    s0 = m0 >> sh;
    s1 = m1 >> sh;
    s2 = m2 >> sh;
    r0 = d0[POS_W] ? -s0[EDGE_W-1:0] : s0[EDGE_W-1:0];
    r1 = d1[POS_W] ? -s1[EDGE_W-1:0] : s1[EDGE_W-1:0];
    r2 = d2[POS_W] ? -s2[EDGE_W-1:0] : s2[EDGE_W-1:0];
    return {r0, r1, r2};
  endfunction

  logic signed [POS_W-1:0] pa_q [3];
  logic signed [EDGE_W-1:0] e1_q [3];
  logic signed [EDGE_W-1:0] e2_q [3];
  logic signed [POS_W:0] dif [3];
  logic [3*EDGE_W-1:0] shr;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif[i] = (POS_W+1)'($signed(pos_rdata_q[PW-1-i*POS_W -: POS_W])) - (POS_W+1)'(pa_q[i]);
    end
    shr = shrink(dif[0], dif[1], dif[2]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_cap) begin
      for (int i = 0; i < 3; i++) begin
        if (cmd_i.cap_corner == CORNER_A) begin
          pa_q[i] <= $signed(pos_rdata_q[PW-1-i*POS_W -: POS_W]);
        end else if (cmd_i.cap_corner == CORNER_B) begin
          e1_q[i] <= $signed(shr[3*EDGE_W-1-i*EDGE_W -: EDGE_W]);
        end else begin
          e2_q[i] <= $signed(shr[3*EDGE_W-1-i*EDGE_W -: EDGE_W]);
        end
      end
    end
  end

  // cross product, one product a cycle, each product registered and then accumulated
  logic signed [EDGE_W-1:0] mop_a, mop_b;
  logic signed [PROD_W-1:0] prod_q;
  logic [2:0]               pstep_q;
  logic                     pv_q;
  logic signed [CRS_W-1:0]  cr_q [3];

  always_comb begin
    case (cmd_i.mul_step)
      3'd0:    begin mop_a = e1_q[1]; mop_b = e2_q[2]; end
      3'd1:    begin mop_a = e1_q[2]; mop_b = e2_q[1]; end
      3'd2:    begin mop_a = e1_q[2]; mop_b = e2_q[0]; end
      3'd3:    begin mop_a = e1_q[0]; mop_b = e2_q[2]; end
      3'd4:    begin mop_a = e1_q[0]; mop_b = e2_q[1]; end
      3'd5:    begin mop_a = e1_q[1]; mop_b = e2_q[0]; end
      default: begin mop_a = '0; mop_b = '0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= cmd_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q  <= mop_a * mop_b;
      pstep_q <= cmd_i.mul_step;
    end
    if (pv_q) begin
      if (!pstep_q[0]) cr_q[pstep_q[2:1]] <= CRS_W'(prod_q);
      else             cr_q[pstep_q[2:1]] <= cr_q[pstep_q[2:1]] - CRS_W'(prod_q);
    end
  end

  // sum store
  logic [SW3-1:0] sum_mem [VERTEX_COUNT];
  logic [SW3-1:0] sum_rdata_q;
  logic [SW3-1:0] sum_wdata;

  // normalize: all three magnitudes shifted together one bit a cycle until the largest is in [2^29, 2^30)
  logic [MAG_W-1:0] m_q [3];
  logic             neg_q [3];
  logic [MAG_W-1:0] top;
  logic signed [MAG_W:0] sx [3];

  assign top = m_q[0] | m_q[1] | m_q[2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sx[i] = (MAG_W+1)'($signed(sum_rdata_q[SW3-1-i*SUM_WIDTH -: SUM_WIDTH]));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd_i.nrm_ld_cross) begin
        neg_q[i] <= cr_q[i][CRS_W-1];
        m_q[i]   <= cr_q[i][CRS_W-1] ? MAG_W'(-cr_q[i]) : MAG_W'(cr_q[i]);
      end else if (cmd_i.nrm_ld_sum) begin
        neg_q[i] <= sx[i][MAG_W];
        m_q[i]   <= sx[i][MAG_W] ? MAG_W'(-sx[i]) : MAG_W'(sx[i]);
      end else if (cmd_i.nrm_shift) begin
        if (sts_o.nrm_big) m_q[i] <= m_q[i] >> 1;
        else               m_q[i] <= m_q[i] << 1;
      end
    end
  end

  // sum of squares
  logic [SQ_W-1:0]  sqp_q;
  logic             sqv_q;
  logic [MAG_W-1:0] ssum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqv_q <= 1'b0;
    end else begin
      sqv_q <= cmd_i.sq_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      sqp_q <= m_q[cmd_i.sq_idx][29:0] * m_q[cmd_i.sq_idx][29:0];
    end
    if (cmd_i.sq_clr)  ssum_q <= '0;
    else if (sqv_q)    ssum_q <= ssum_q + MAG_W'(sqp_q);
  end

  // integer square root, one result bit a cycle
  logic [RT_W-1:0] x_q, r_q, bit_q, rt_try;
  assign rt_try = r_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      x_q   <= RT_W'(ssum_q);
      r_q   <= '0;
      bit_q <= RT_W'(1) << 62;
    end else if (cmd_i.sqrt_step) begin
      if (x_q >= rt_try) begin
        x_q <= x_q - rt_try;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  logic [LEN_W-1:0] len;
  assign len = r_q[LEN_W-1:0];

  // three restoring dividers, one quotient bit a cycle
  logic [REM_W-1:0] rem_q [3];
  logic [NRM_W-1:0] low_q [3];
  logic [NRM_W-1:0] quo_q [3];
  logic [NUM_W-1:0] num [3];
  logic [REM_W:0]   dt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, m_q[i][29:0], 14'd0} + NUM_W'(len >> 1);
      dt[i]  = {rem_q[i], low_q[i][NRM_W-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd_i.div_init) begin
        rem_q[i] <= REM_W'(num[i][NUM_W-1:NRM_W]);
        low_q[i] <= num[i][NRM_W-1:0];
        quo_q[i] <= '0;
      end else if (cmd_i.div_step) begin
        if (dt[i] >= (REM_W+1)'(len)) begin
          rem_q[i] <= REM_W'(dt[i] - (REM_W+1)'(len));
          quo_q[i] <= {quo_q[i][NRM_W-2:0], 1'b1};
        end else begin
          rem_q[i] <= dt[i][REM_W-1:0];
          quo_q[i] <= {quo_q[i][NRM_W-2:0], 1'b0};
        end
        low_q[i] <= low_q[i] << 1;
      end
    end
  end

  logic signed [NRM_W-1:0] nv [3];
  logic signed [SUM_WIDTH:0] sadd [3];
  logic signed [SUM_WIDTH-1:0] ssat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nv[i] = ($signed(quo_q[i]) > NrmOne) ? NrmOne : $signed(quo_q[i]);
      if (neg_q[i]) nv[i] = -nv[i];
      sadd[i] = (SUM_WIDTH+1)'($signed(sum_rdata_q[SW3-1-i*SUM_WIDTH -: SUM_WIDTH]))
              + (SUM_WIDTH+1)'(nv[i]);
      if (sadd[i] > SumMax)      ssat[i] = SUM_WIDTH'(SumMax);
      else if (sadd[i] < SumMin) ssat[i] = SUM_WIDTH'(SumMin);
      else                       ssat[i] = SUM_WIDTH'(sadd[i]);
    end
    sum_wdata = {ssat[0], ssat[1], ssat[2]};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_vertex) begin
      sum_mem[a_addr] <= '0;
    end else if (cmd_i.sum_wr) begin
      sum_mem[sum_addr] <= sum_wdata;
    end
    if (cmd_i.sum_rd) begin
      sum_rdata_q <= sum_mem[sum_addr];
    end
  end

  // result register
  logic                    done_q;
  logic [IDX_W-1:0]        vidx_q;
  logic signed [NRM_W-1:0] nrm_q [3];
  logic                    zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.out_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_fire) begin
      vidx_q <= ia_q;
      zero_q <= cmd_i.out_zero;
      for (int i = 0; i < 3; i++) begin
        nrm_q[i] <= cmd_i.out_zero ? '0 : nv[i];
      end
    end
  end

  assign done_o         = done_q;
  assign vertex_index_o = vidx_q;
  assign normal_x_o     = nrm_q[0];
  assign normal_y_o     = nrm_q[1];
  assign normal_z_o     = nrm_q[2];
  assign zero_normal_o  = zero_q;

  assign sts_o.act       = act_q;
  assign sts_o.a_ok      = a_ok;
  assign sts_o.tri_ok    = a_ok & b_ok & c_ok;
  assign sts_o.m_zero    = (top == '0);
  assign sts_o.nrm_big   = |top[MAG_W-1:30];
  assign sts_o.nrm_small = ~|top[MAG_W-1:29];

endmodule

FILE: hdl/vna_ctrl.sv
// ----------------------------------------------------------------------------
// vna_ctrl
// sequencer for write, triangle and read items
// ----------------------------------------------------------------------------
`include "vertex_normal_accumulator_assert.svh"

module vna_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  vna_pkg::vna_sts_t sts_i,
  output vna_pkg::vna_cmd_t cmd_o
);
  import vna_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_POS    = 4'd2;
  localparam logic [3:0] S_MUL    = 4'd3;
  localparam logic [3:0] S_NLOAD  = 4'd4;
  localparam logic [3:0] S_SUMRD  = 4'd5;
  localparam logic [3:0] S_SUMLD  = 4'd6;
  localparam logic [3:0] S_NORM   = 4'd7;
  localparam logic [3:0] S_SQ     = 4'd8;
  localparam logic [3:0] S_SQRT_I = 4'd9;
  localparam logic [3:0] S_SQRT   = 4'd10;
  localparam logic [3:0] S_DIV_I  = 4'd11;
  localparam logic [3:0] S_DIV    = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;
  localparam logic [3:0] S_ACC_RD = 4'd14;
  localparam logic [3:0] S_ACC_WR = 4'd15;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             is_tri;

  assign is_tri = (sts_i.act == ACT_TRI);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.cap_in = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        cnt_d = '0;
        case (sts_i.act)
          ACT_WRITE: begin
            cmd_o.wr_vertex = sts_i.a_ok;
            state_d         = S_IDLE;
          end
          ACT_TRI: begin
            state_d = sts_i.tri_ok ? S_POS : S_IDLE;
          end
          ACT_READ: begin
            if (sts_i.a_ok) begin
              state_d = S_SUMRD;
            end else begin
              cmd_o.out_fire = 1'b1;
              cmd_o.out_zero = 1'b1;
              state_d        = S_IDLE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_POS: begin
        // read corner n while capturing corner n-1
        cmd_o.pos_rd     = (cnt_q < CNT_W'(3));
        cmd_o.rd_corner  = cnt_q[1:0];
        cmd_o.pos_cap    = (cnt_q != '0);
        cmd_o.cap_corner = cnt_q[1:0] - 2'd1;
        if (cnt_q == CNT_W'(3)) begin
          cnt_d   = '0;
          state_d = S_MUL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.mul_en   = (cnt_q < CNT_W'(6));
        cmd_o.mul_step = cnt_q[2:0];
        if (cnt_q == CNT_W'(6)) begin
          state_d = S_NLOAD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_NLOAD: begin
        cmd_o.nrm_ld_cross = 1'b1;
        state_d            = S_NORM;
      end
      S_SUMRD: begin
        cmd_o.sum_rd     = 1'b1;
        cmd_o.sum_corner = CORNER_A;
        state_d          = S_SUMLD;
      end
      S_SUMLD: begin
        cmd_o.nrm_ld_sum = 1'b1;
        state_d          = S_NORM;
      end
      S_NORM: begin
        cnt_d = '0;
        if (sts_i.m_zero) begin
          // degenerate triangle adds nothing, zero read reports the flag
          cmd_o.out_fire = !is_tri;
          cmd_o.out_zero = 1'b1;
          state_d        = S_IDLE;
        end else if (sts_i.nrm_big || sts_i.nrm_small) begin
          cmd_o.nrm_shift = 1'b1;
        end else begin
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.sq_clr = (cnt_q == '0);
        cmd_o.sq_en  = (cnt_q < CNT_W'(3));
        cmd_o.sq_idx = cnt_q[1:0];
        if (cnt_q == CNT_W'(3)) begin
          state_d = S_SQRT_I;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SQRT_I: begin
        cmd_o.sqrt_init = 1'b1;
        cnt_d           = '0;
        state_d         = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(31)) begin
          state_d = S_DIV_I;
        end
      end
      S_DIV_I: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(15)) begin
          cnt_d   = '0;
          state_d = is_tri ? S_ACC_RD : S_OUT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_OUT: begin
        cmd_o.out_fire = 1'b1;
        state_d        = S_IDLE;
      end
      S_ACC_RD: begin
        cmd_o.sum_rd     = 1'b1;
        cmd_o.sum_corner = cnt_q[1:0];
        state_d          = S_ACC_WR;
      end
      S_ACC_WR: begin
        cmd_o.sum_wr     = 1'b1;
        cmd_o.sum_corner = cnt_q[1:0];
        if (cnt_q == CNT_W'(2)) begin
          state_d = S_IDLE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_ACC_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

  `VNA_ASSERT_NXT(a_accept_decodes, (state_q == S_IDLE) && start, state_q == S_DECODE)
  `VNA_ASSERT_IMP(a_fire_only_read, cmd_o.out_fire, sts_i.act == ACT_READ)
  `VNA_ASSERT_IMP(a_acc_only_tri, cmd_o.sum_wr, (sts_i.act == ACT_TRI) && sts_i.tri_ok)
  `VNA_ASSERT_IMP(a_norm_ready_sq, (state_q == S_SQ) && (cnt_q == '0),
                  !sts_i.nrm_big && !sts_i.nrm_small && !sts_i.m_zero)

endmodule
